// File: src/ttf_pkg.sv
// Shared types and constants for the triangle tangent frame block.
// Holds the payload structs, the controller/datapath command and status structs.
// No dependencies.
package ttf_pkg;

    // Field widths fixed by the interface.
    localparam int COORD_W       = 32;
    localparam int OUT_W         = 16;
    localparam int OUT_FRAC_BITS = 14;

    // Internal widths derived from the field widths.
    localparam int DELTA_W   = COORD_W + 1;
    localparam int PROD_W    = 2 * DELTA_W;
    localparam int ACC_W     = PROD_W + 1;
    localparam int LEN_W     = $clog2(ACC_W + 1);
    localparam int NORM_BITS = 30;
    localparam int SUM_W     = 2 * NORM_BITS + 2;
    localparam int ROOT_W    = SUM_W / 2;
    localparam int ROOT_STEPS = SUM_W / 2;
    localparam int DIV_W     = NORM_BITS + OUT_FRAC_BITS + 2;
    localparam int QUO_W     = OUT_FRAC_BITS + 1;

    // Multiplier operand select codes.
    localparam int SEL_W      = 5;
    localparam int MUL_DET0   = 0;
    localparam int MUL_T0     = 2;
    localparam int MUL_B0     = 8;
    localparam int MUL_PAIRS  = 14;
    localparam int MUL_SQ0    = 14;

    localparam int CNT_W = 5;

    typedef struct packed {
        logic signed [COORD_W-1:0] pos_x;
        logic signed [COORD_W-1:0] pos_y;
        logic signed [COORD_W-1:0] pos_z;
        logic signed [COORD_W-1:0] tex_u;
        logic signed [COORD_W-1:0] tex_v;
    } t_in_beat;

    typedef struct packed {
        logic signed [OUT_W-1:0] tangent_x;
        logic signed [OUT_W-1:0] tangent_y;
        logic signed [OUT_W-1:0] tangent_z;
        logic signed [OUT_W-1:0] bitangent_x;
        logic signed [OUT_W-1:0] bitangent_y;
        logic signed [OUT_W-1:0] bitangent_z;
        logic                    degenerate;
    } t_out_beat;

    typedef enum logic [1:0] {
        ACC_HOLD,
        ACC_LOAD,
        ACC_ADD,
        ACC_SUB
    } t_acc_op;

    typedef struct packed {
        logic             store_corner;
        logic             corner_idx;
        logic             load_delta;
        logic             mul_en;
        logic [SEL_W-1:0] mul_sel;
        t_acc_op          acc_op;
        logic             wr_en;
        logic [2:0]       wr_idx;
        logic             abs_en;
        logic             vec_sel;
        logic             len_en;
        logic             shift_en;
        logic             root_init;
        logic             root_step;
        logic             div_init;
        logic             div_step;
        logic             div_store;
        logic [1:0]       comp_idx;
        logic             out_load;
        logic             out_degen;
    } t_cmd;

    typedef struct packed {
        logic det_zero;
        logic len_zero;
        logic out_free;
    } t_status;

endpackage

// File: src/ttf_ctrl.sv
// Sequencer for the triangle tangent frame block.
// Counts corners and steps the datapath through multiply, normalize, square root and divide.
// Depends on ttf_pkg.
module ttf_ctrl
    import ttf_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL,
        S_DET,
        S_ABS,
        S_LEN,
        S_SHIFT,
        S_SQ,
        S_ROOT_INIT,
        S_ROOT,
        S_DIV_INIT,
        S_DIV,
        S_DIV_STORE,
        S_FINISH
    } t_state;

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [1:0]       r_corners, n_corners;
    logic             r_vec, n_vec;
    logic [1:0]       r_comp, n_comp;
    logic             r_degen, n_degen;
    logic [CNT_W-1:0] k_prev;

    // Next state and command decode.
    always_comb begin
        n_state   = r_state;
        n_cnt     = r_cnt;
        n_corners = r_corners;
        n_vec     = r_vec;
        n_comp    = r_comp;
        n_degen   = r_degen;
        o_cmd     = '0;
        o_in_ready = 1'b0;
        k_prev    = r_cnt - CNT_W'(1);
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    if (r_corners < 2'd2) begin
                        o_cmd.store_corner = 1'b1;
                        o_cmd.corner_idx   = r_corners[0];
                        n_corners          = r_corners + 2'd1;
                    end else begin
                        o_cmd.load_delta = 1'b1;
                        n_corners        = '0;
                        n_cnt            = '0;
                        n_degen          = 1'b0;
                        n_state          = S_MUL;
                    end
                end
            end
            S_MUL: begin
                // Product k is formed while product k-1 is folded in.
                if (r_cnt < CNT_W'(MUL_PAIRS)) begin
                    o_cmd.mul_en  = 1'b1;
                    o_cmd.mul_sel = SEL_W'(r_cnt);
                end
                if (r_cnt != '0) begin
                    if (r_cnt[0]) begin
                        o_cmd.acc_op = ACC_LOAD;
                    end else begin
                        o_cmd.acc_op = ACC_SUB;
                        o_cmd.wr_en  = 1'b1;
                        o_cmd.wr_idx = k_prev[3:1];
                    end
                end
                if (r_cnt == CNT_W'(MUL_PAIRS)) begin
                    n_state = S_DET;
                end else begin
                    n_cnt = r_cnt + CNT_W'(1);
                end
            end
            S_DET: begin
                if (i_status.det_zero) begin
                    n_degen = 1'b1;
                    n_state = S_FINISH;
                end else begin
                    n_vec   = 1'b0;
                    n_state = S_ABS;
                end
            end
            S_ABS: begin
                o_cmd.abs_en  = 1'b1;
                o_cmd.vec_sel = r_vec;
                n_state       = S_LEN;
            end
            S_LEN: begin
                o_cmd.len_en = 1'b1;
                n_state      = S_SHIFT;
            end
            S_SHIFT: begin
                if (i_status.len_zero) begin
                    n_degen = 1'b1;
                    n_state = S_FINISH;
                end else begin
                    o_cmd.shift_en = 1'b1;
                    n_cnt          = '0;
                    n_state        = S_SQ;
                end
            end
            S_SQ: begin
                // Sum of squares of the three scaled components.
                if (r_cnt < CNT_W'(3)) begin
                    o_cmd.mul_en  = 1'b1;
                    o_cmd.mul_sel = SEL_W'(MUL_SQ0) + SEL_W'(r_cnt);
                end
                if (r_cnt == CNT_W'(1)) begin
                    o_cmd.acc_op = ACC_LOAD;
                end else if (r_cnt != '0) begin
                    o_cmd.acc_op = ACC_ADD;
                end
                if (r_cnt == CNT_W'(3)) begin
                    n_state = S_ROOT_INIT;
                end else begin
                    n_cnt = r_cnt + CNT_W'(1);
                end
            end
            S_ROOT_INIT: begin
                o_cmd.root_init = 1'b1;
                n_cnt           = '0;
                n_state         = S_ROOT;
            end
            S_ROOT: begin
                o_cmd.root_step = 1'b1;
                if (r_cnt == CNT_W'(ROOT_STEPS - 1)) begin
                    n_comp  = '0;
                    n_state = S_DIV_INIT;
                end else begin
                    n_cnt = r_cnt + CNT_W'(1);
                end
            end
            S_DIV_INIT: begin
                o_cmd.div_init = 1'b1;
                o_cmd.comp_idx = r_comp;
                n_cnt          = '0;
                n_state        = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (r_cnt == CNT_W'(QUO_W - 1)) begin
                    n_state = S_DIV_STORE;
                end else begin
                    n_cnt = r_cnt + CNT_W'(1);
                end
            end
            S_DIV_STORE: begin
                o_cmd.div_store = 1'b1;
                o_cmd.comp_idx  = r_comp;
                o_cmd.vec_sel   = r_vec;
                if (r_comp == 2'd2) begin
                    if (!r_vec) begin
                        n_vec   = 1'b1;
                        n_state = S_ABS;
                    end else begin
                        n_state = S_FINISH;
                    end
                end else begin
                    n_comp  = r_comp + 2'd1;
                    n_state = S_DIV_INIT;
                end
            end
            S_FINISH: begin
                // Wait for the output register to free up.
                if (i_status.out_free) begin
                    o_cmd.out_load  = 1'b1;
                    o_cmd.out_degen = r_degen;
                    n_state         = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_cnt     <= '0;
            r_corners <= '0;
            r_vec     <= 1'b0;
            r_comp    <= '0;
            r_degen   <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cnt     <= n_cnt;
            r_corners <= n_corners;
            r_vec     <= n_vec;
            r_comp    <= n_comp;
            r_degen   <= n_degen;
        end
    end

endmodule

// File: src/ttf_datapath.sv
// Datapath of the triangle tangent frame block: corner store, shared multiplier,
// normalizer, bit-serial square root, serial divider and output register.
// Depends on ttf_pkg.
module ttf_datapath
    import ttf_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_in_beat  i_in_data,
    input  t_cmd      i_cmd,
    output t_status   o_status,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_beat o_out_data
);

    // Held corners and edge deltas.
    logic signed [COORD_W-1:0] r_p0 [3];
    logic signed [COORD_W-1:0] r_p1 [3];
    logic signed [COORD_W-1:0] r_u0, r_v0, r_u1, r_v1;
    logic signed [DELTA_W-1:0] r_e1 [3];
    logic signed [DELTA_W-1:0] r_e2 [3];
    logic signed [DELTA_W-1:0] r_d1u, r_d1v, r_d2u, r_d2v;
    logic signed [COORD_W-1:0] in_pos [3];

    // Multiply and accumulate.
    logic signed [DELTA_W-1:0] m_a, m_b;
    logic [SEL_W-1:0]          sel_off;
    logic [1:0]                sel_c;
    logic signed [PROD_W-1:0]  r_prod;
    logic signed [ACC_W-1:0]   r_acc, prod_ext, acc_diff;
    logic signed [ACC_W-1:0]   r_det;
    logic signed [ACC_W-1:0]   r_tan [3];
    logic signed [ACC_W-1:0]   r_btn [3];

    // Normalization.
    logic [ACC_W-1:0]     r_mag [3];
    logic                 r_neg [3];
    logic [LEN_W-1:0]     r_len;
    logic [NORM_BITS-1:0] r_s [3];
    logic [NORM_BITS-1:0] s_next [3];
    logic [ACC_W-1:0]     sh_dn [3];
    logic [ACC_W-1:0]     sh_up [3];
    logic [LEN_W-1:0]     amt_dn, amt_up;
    logic signed [ACC_W-1:0] vsel [3];

    // Square root and divider.
    logic [SUM_W-1:0]  r_x, r_r, r_bit, root_trial;
    logic [ROOT_W-1:0] len_root;
    logic [DIV_W-1:0]  r_rem, r_den;
    logic [QUO_W-1:0]  r_quo, quo_cl;
    logic signed [OUT_W-1:0] quo_signed;

    // Result staging and output register.
    logic signed [OUT_W-1:0] r_res_t [3];
    logic signed [OUT_W-1:0] r_res_b [3];
    logic      r_out_valid;
    t_out_beat r_out_data;

    // Leading-one position plus one; zero for a zero word.
    function automatic logic [LEN_W-1:0] f_bitlen(input logic [ACC_W-1:0] x);
        logic [LEN_W-1:0] n;
        n = '0;
        for (int i = 0; i < ACC_W; i++) begin
            if (x[i]) begin
                n = LEN_W'(i + 1);
            end
        end
        return n;
    endfunction

    assign in_pos[0] = i_in_data.pos_x;
    assign in_pos[1] = i_in_data.pos_y;
    assign in_pos[2] = i_in_data.pos_z;

    // Corner store and edge deltas on the third corner.
    always_ff @(posedge i_clk) begin
        if (i_cmd.store_corner) begin
            for (int i = 0; i < 3; i++) begin
                if (i_cmd.corner_idx) begin
                    r_p1[i] <= in_pos[i];
                end else begin
                    r_p0[i] <= in_pos[i];
                end
            end
            if (i_cmd.corner_idx) begin
                r_u1 <= i_in_data.tex_u;
                r_v1 <= i_in_data.tex_v;
            end else begin
                r_u0 <= i_in_data.tex_u;
                r_v0 <= i_in_data.tex_v;
            end
        end
        if (i_cmd.load_delta) begin
            for (int i = 0; i < 3; i++) begin
                r_e1[i] <= DELTA_W'(r_p1[i]) - DELTA_W'(r_p0[i]);
                r_e2[i] <= DELTA_W'(in_pos[i]) - DELTA_W'(r_p0[i]);
            end
            r_d1u <= DELTA_W'(r_u1) - DELTA_W'(r_u0);
            r_d1v <= DELTA_W'(r_v1) - DELTA_W'(r_v0);
            r_d2u <= DELTA_W'(i_in_data.tex_u) - DELTA_W'(r_u0);
            r_d2v <= DELTA_W'(i_in_data.tex_v) - DELTA_W'(r_v0);
        end
    end

    // Multiplier operand select.
    always_comb begin
        m_a     = '0;
        m_b     = '0;
        sel_off = '0;
        sel_c   = '0;
        if (i_cmd.mul_sel < SEL_W'(MUL_T0)) begin
            if (i_cmd.mul_sel == SEL_W'(MUL_DET0)) begin
                m_a = r_d1u;
                m_b = r_d2v;
            end else begin
                m_a = r_d2u;
                m_b = r_d1v;
            end
        end else if (i_cmd.mul_sel < SEL_W'(MUL_B0)) begin
            sel_off = i_cmd.mul_sel - SEL_W'(MUL_T0);
            sel_c   = sel_off[2:1];
            if (!sel_off[0]) begin
                m_a = r_d2v;
                m_b = r_e1[sel_c];
            end else begin
                m_a = r_d1v;
                m_b = r_e2[sel_c];
            end
        end else if (i_cmd.mul_sel < SEL_W'(MUL_SQ0)) begin
            sel_off = i_cmd.mul_sel - SEL_W'(MUL_B0);
            sel_c   = sel_off[2:1];
            if (!sel_off[0]) begin
                m_a = r_d1u;
                m_b = r_e2[sel_c];
            end else begin
                m_a = r_d2u;
                m_b = r_e1[sel_c];
            end
        end else begin
            sel_off = i_cmd.mul_sel - SEL_W'(MUL_SQ0);
            sel_c   = sel_off[1:0];
            m_a     = {{(DELTA_W - NORM_BITS){1'b0}}, r_s[sel_c]};
            m_b     = {{(DELTA_W - NORM_BITS){1'b0}}, r_s[sel_c]};
        end
    end

    assign prod_ext = ACC_W'(r_prod);
    assign acc_diff = r_acc - prod_ext;

    // Product register, accumulator and cross-product results.
    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_en) begin
            r_prod <= m_a * m_b;
        end
        case (i_cmd.acc_op)
            ACC_LOAD: r_acc <= prod_ext;
            ACC_ADD:  r_acc <= r_acc + prod_ext;
            ACC_SUB:  r_acc <= acc_diff;
            default:  r_acc <= r_acc;
        endcase
        if (i_cmd.wr_en) begin
            if (i_cmd.wr_idx == 3'd0) begin
                r_det <= acc_diff;
            end else if (i_cmd.wr_idx < 3'd4) begin
                r_tan[2'(i_cmd.wr_idx - 3'd1)] <= acc_diff;
            end else begin
                r_btn[2'(i_cmd.wr_idx - 3'd4)] <= acc_diff;
            end
        end
    end

    // Scale so the largest magnitude has exactly NORM_BITS bits.
    always_comb begin
        amt_dn = r_len - LEN_W'(NORM_BITS);
        amt_up = LEN_W'(NORM_BITS) - r_len;
        for (int i = 0; i < 3; i++) begin
            vsel[i]  = i_cmd.vec_sel ? r_btn[i] : r_tan[i];
            sh_dn[i] = r_mag[i] >> amt_dn;
            sh_up[i] = r_mag[i] << amt_up;
            if (r_len > LEN_W'(NORM_BITS)) begin
                s_next[i] = sh_dn[i][NORM_BITS-1:0];
            end else begin
                s_next[i] = sh_up[i][NORM_BITS-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.abs_en) begin
            for (int i = 0; i < 3; i++) begin
                r_mag[i] <= vsel[i][ACC_W-1] ? ACC_W'(-vsel[i]) : ACC_W'(vsel[i]);
                r_neg[i] <= vsel[i][ACC_W-1] ^ r_det[ACC_W-1];
            end
        end
        if (i_cmd.len_en) begin
            r_len <= f_bitlen(r_mag[0] | r_mag[1] | r_mag[2]);
        end
        if (i_cmd.shift_en) begin
            for (int i = 0; i < 3; i++) begin
                r_s[i] <= s_next[i];
            end
        end
    end

    // Digit-by-digit integer square root, one result bit per cycle.
    assign root_trial = r_r + r_bit;
    assign len_root   = r_r[ROOT_W-1:0];

    always_ff @(posedge i_clk) begin
        if (i_cmd.root_init) begin
            r_x   <= r_acc[SUM_W-1:0];
            r_r   <= '0;
            r_bit <= SUM_W'(1) << (SUM_W - 2);
        end else if (i_cmd.root_step) begin
            if (r_x >= root_trial) begin
                r_x <= r_x - root_trial;
                r_r <= (r_r >> 1) + r_bit;
            end else begin
                r_r <= r_r >> 1;
            end
            r_bit <= r_bit >> 2;
        end
    end

    // Rounded restoring divider, one quotient bit per cycle.
    always_comb begin
        if (r_quo > QUO_W'(1 << OUT_FRAC_BITS)) begin
            quo_cl = QUO_W'(1 << OUT_FRAC_BITS);
        end else begin
            quo_cl = r_quo;
        end
        if (r_neg[i_cmd.comp_idx]) begin
            quo_signed = -OUT_W'(quo_cl);
        end else begin
            quo_signed = OUT_W'(quo_cl);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_init) begin
            r_rem <= (DIV_W'(r_s[i_cmd.comp_idx]) << OUT_FRAC_BITS)
                     + DIV_W'(len_root >> 1);
            r_den <= DIV_W'(len_root) << OUT_FRAC_BITS;
            r_quo <= '0;
        end else if (i_cmd.div_step) begin
            if (r_rem >= r_den) begin
                r_rem <= r_rem - r_den;
                r_quo <= {r_quo[QUO_W-2:0], 1'b1};
            end else begin
                r_quo <= {r_quo[QUO_W-2:0], 1'b0};
            end
            r_den <= r_den >> 1;
        end
        if (i_cmd.div_store) begin
            if (i_cmd.vec_sel) begin
                r_res_b[i_cmd.comp_idx] <= quo_signed;
            end else begin
                r_res_t[i_cmd.comp_idx] <= quo_signed;
            end
        end
    end

    // Output register; a new result may load in the beat the old one leaves.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
        if (i_cmd.out_load) begin
            if (i_cmd.out_degen) begin
                // All vector fields zero, degenerate flag set.
                r_out_data <= {{(6 * OUT_W){1'b0}}, 1'b1};
            end else begin
                r_out_data.tangent_x   <= r_res_t[0];
                r_out_data.tangent_y   <= r_res_t[1];
                r_out_data.tangent_z   <= r_res_t[2];
                r_out_data.bitangent_x <= r_res_b[0];
                r_out_data.bitangent_y <= r_res_b[1];
                r_out_data.bitangent_z <= r_res_b[2];
                r_out_data.degenerate  <= 1'b0;
            end
        end
    end

    assign o_status.det_zero = (r_det == '0);
    assign o_status.len_zero = (r_len == '0);
    assign o_status.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

// File: src/triangle_tangent_frame.sv
// Triangle tangent frame: top level joining the sequencer and the datapath.
// Depends on ttf_pkg, ttf_ctrl and ttf_datapath.
//
// Usage: corners stream in on the input channel (valid/ready), three beats per
// triangle: position and texture coordinate, all Q16.16. The first two corners
// are held. The third corner starts the frame work and produces one output
// beat: unit tangent and bitangent in Q1.14, or all zero with the degenerate
// flag when the uv determinant or a vector is zero.
// The work runs through the shared 33x33 multiplier (14 products, then three
// squares per vector), the 31-step bit-serial square root once per vector and
// the 15-step serial divider once per component. A zero determinant skips
// normalization and goes straight to the output. Input ready is low while a
// triangle is being processed.
// The result sits in an output register; corners of the next triangle are
// taken while it waits; a stalled receiver holds the next frame and the input back.
// Reset returns the corner count to zero and empties the output register.
module triangle_tangent_frame
    import ttf_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_beat  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_beat o_out_data
);

    t_cmd    cmd;
    t_status status;

    // Sequencer.
    ttf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    // Arithmetic and storage.
    ttf_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cmd       (cmd),
        .o_status    (status),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

// File: bench/tb.sv
// Self-checking testbench for triangle_tangent_frame: corners in, unit frames out.
// Depends on ttf_pkg and the triangle_tangent_frame RTL; it predicts each frame itself.
module tb;
    import ttf_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    typedef logic signed [127:0] t_wide;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_in_valid = 1'b0;
    logic      o_in_ready;
    t_in_beat  i_in_data = '0;
    logic      o_out_valid;
    logic      i_out_ready = 1'b0;
    t_out_beat o_out_data;

    t_in_beat  corner_queue[$];
    t_out_beat frame_queue[$];
    int        error_count = 0;
    int        tx_idle_pct = 0;
    int        rx_stall_pct = 0;
    int        rx_hold_left = 0;
    bit        rx_hold_go = 1'b0;
    bit        rx_hold_done = 1'b0;
    int        quiet_cycles = 0;
    bit        tx_pause = 1'b0;

    // Predictor state: corners held of the current triangle.
    int        held_count = 0;
    t_in_beat  held_corner[2];

    triangle_tangent_frame u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Integer square root, floor.
    function automatic logic [63:0] root_floor(input logic [63:0] x);
        logic [63:0] r;
        logic [63:0] b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x) b = b >> 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // Scales a vector to unit length in Q1.14; returns 0 for a zero vector.
    function automatic bit unit_vector(input t_wide v[3], output logic [15:0] q[3]);
        t_wide       mag[3];
        int          m;
        int          bl;
        logic [63:0] s[3];
        logic [63:0] sum;
        logic [63:0] len;
        logic [63:0] r;
        m = 0;
        sum = 0;
        for (int i = 0; i < 3; i++) begin
            mag[i] = (v[i] < 0) ? -v[i] : v[i];
            bl = 0;
            for (int k = 0; k < 128; k++) if (mag[i][k]) bl = k + 1;
            if (bl > m) m = bl;
        end
        if (m == 0) return 1'b0;
        for (int i = 0; i < 3; i++) begin
            if (m > NORM_BITS) s[i] = 64'(mag[i] >> (m - NORM_BITS));
            else s[i] = 64'(mag[i] << (NORM_BITS - m));
            s[i] = s[i] & ((64'd1 << NORM_BITS) - 1);
            sum = sum + s[i] * s[i];
        end
        len = root_floor(sum);
        for (int i = 0; i < 3; i++) begin
            r = ((s[i] << OUT_FRAC_BITS) + (len >> 1)) / len;
            if (r > (64'd1 << OUT_FRAC_BITS)) r = 64'd1 << OUT_FRAC_BITS;
            q[i] = (v[i] < 0) ? 16'(-r) : 16'(r);
        end
        return 1'b1;
    endfunction

    // Takes one corner; on the third it queues the expected frame.
    function automatic void take_corner(input t_in_beat c);
        t_wide       p0[3];
        t_wide       e1[3];
        t_wide       e2[3];
        t_wide       tv[3];
        t_wide       bv[3];
        t_wide       d1u, d1v, d2u, d2v, det;
        logic [15:0] qt[3];
        logic [15:0] qb[3];
        bit          ok;
        t_out_beat   f;
        if (held_count < 2) begin
            held_corner[held_count] = c;
            held_count++;
            return;
        end
        held_count = 0;
        p0[0] = held_corner[0].pos_x;
        p0[1] = held_corner[0].pos_y;
        p0[2] = held_corner[0].pos_z;
        e1[0] = t_wide'(held_corner[1].pos_x) - p0[0];
        e1[1] = t_wide'(held_corner[1].pos_y) - p0[1];
        e1[2] = t_wide'(held_corner[1].pos_z) - p0[2];
        e2[0] = t_wide'(c.pos_x) - p0[0];
        e2[1] = t_wide'(c.pos_y) - p0[1];
        e2[2] = t_wide'(c.pos_z) - p0[2];
        d1u = t_wide'(held_corner[1].tex_u) - t_wide'(held_corner[0].tex_u);
        d1v = t_wide'(held_corner[1].tex_v) - t_wide'(held_corner[0].tex_v);
        d2u = t_wide'(c.tex_u) - t_wide'(held_corner[0].tex_u);
        d2v = t_wide'(c.tex_v) - t_wide'(held_corner[0].tex_v);
        det = d1u * d2v - d2u * d1v;
        for (int i = 0; i < 3; i++) begin
            tv[i] = d2v * e1[i] - d1v * e2[i];
            bv[i] = d1u * e2[i] - d2u * e1[i];
            if (det < 0) begin
                tv[i] = -tv[i];
                bv[i] = -bv[i];
            end
        end
        ok = (det != 0);
        if (ok) ok = unit_vector(tv, qt);
        if (ok) ok = unit_vector(bv, qb);
        f = '0;
        f.degenerate = !ok;
        if (ok) begin
            f.tangent_x = qt[0];
            f.tangent_y = qt[1];
            f.tangent_z = qt[2];
            f.bitangent_x = qb[0];
            f.bitangent_y = qb[1];
            f.bitangent_z = qb[2];
        end
        frame_queue = {frame_queue, f};
    endfunction

    task automatic report(input string what, input longint got, input longint want);
        $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    // Corner driver: offers the next queued corner unless idling.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) take_corner(i_in_data);
            if (!i_in_valid || o_in_ready) begin
                if (corner_queue.size() > 0 && !tx_pause &&
                    $urandom_range(99) >= tx_idle_pct) begin
                    i_in_valid <= 1'b1;
                    i_in_data <= corner_queue.pop_front();
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Frame monitor: checks each accepted beat and drives ready.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (frame_queue.size() == 0) begin
                report("unexpected beat", 0, 0);
            end else begin
                t_out_beat w;
                w = frame_queue.pop_front();
                if (o_out_data.tangent_x !== w.tangent_x)
                    report("tangent_x", o_out_data.tangent_x, w.tangent_x);
                if (o_out_data.tangent_y !== w.tangent_y)
                    report("tangent_y", o_out_data.tangent_y, w.tangent_y);
                if (o_out_data.tangent_z !== w.tangent_z)
                    report("tangent_z", o_out_data.tangent_z, w.tangent_z);
                if (o_out_data.bitangent_x !== w.bitangent_x)
                    report("bitangent_x", o_out_data.bitangent_x, w.bitangent_x);
                if (o_out_data.bitangent_y !== w.bitangent_y)
                    report("bitangent_y", o_out_data.bitangent_y, w.bitangent_y);
                if (o_out_data.bitangent_z !== w.bitangent_z)
                    report("bitangent_z", o_out_data.bitangent_z, w.bitangent_z);
                if (o_out_data.degenerate !== w.degenerate)
                    report("degenerate", o_out_data.degenerate, w.degenerate);
            end
        end
        i_out_ready <= i_rst_n && rx_hold_left == 0 && $urandom_range(99) >= rx_stall_pct;
    end

    // Long receiver hold-off, started once on request and counted down here.
    always @(posedge i_clk) begin
        if (rx_hold_go && !rx_hold_done) begin
            rx_hold_left <= 1500;
            rx_hold_done <= 1'b1;
        end else if (rx_hold_left > 0) begin
            rx_hold_left <= rx_hold_left - 1;
        end
    end

    // Watchdog on cycles without any beat moving.
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles > 20000) begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    function automatic logic [31:0] rand_coord(input int style, input logic [31:0] base);
        case (style)
            0: return $urandom;
            1: return base + $urandom_range(0, 8191) - 4096;
            2: return base + (($urandom_range(0, 1)) ? 32'h0001_0000 : 32'hFFFF_0000);
            default: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
        endcase
    endfunction

    task automatic add_corner(input logic [31:0] x, y, z, u, v);
        t_in_beat c;
        c.pos_x = x;
        c.pos_y = y;
        c.pos_z = z;
        c.tex_u = u;
        c.tex_v = v;
        corner_queue = {corner_queue, c};
    endtask

    // Random triangles, mostly small nearby corners, some wild.
    task automatic add_triangles(input int n);
        logic [31:0] bp[5];
        int          style;
        for (int t = 0; t < n; t++) begin
            style = $urandom_range(0, 9);
            style = (style < 3) ? 0 : (style < 8) ? 1 : (style < 9) ? 2 : 3;
            for (int k = 0; k < 5; k++) bp[k] = $urandom;
            for (int c = 0; c < 3; c++) begin
                if (style == 2 && c == 2 && $urandom_range(0, 1))
                    add_corner(bp[0], bp[1], bp[2], bp[3], bp[4]);
                else
                    add_corner(rand_coord(style, bp[0]), rand_coord(style, bp[1]),
                               rand_coord(style, bp[2]), rand_coord(style, bp[3]),
                               rand_coord(style, bp[4]));
            end
        end
    endtask

    task automatic drain_all();
        while (corner_queue.size() != 0 || i_in_valid || frame_queue.size() != 0)
            @(posedge i_clk);
        @(posedge i_clk);
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: extremes, zero determinant, zero vectors, both det signs.
        add_corner(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        add_corner(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
        add_corner(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
        add_corner(0, 0, 0, 0, 0);
        add_corner(32'h0001_0000, 0, 0, 32'h0001_0000, 0);
        add_corner(0, 32'h0001_0000, 0, 0, 32'h0001_0000);
        add_corner(0, 0, 0, 0, 0);
        add_corner(32'h0001_0000, 0, 0, 0, 32'h0001_0000);
        add_corner(0, 32'h0001_0000, 0, 32'h0001_0000, 0);
        add_corner(5, 6, 7, 100, 100);
        add_corner(9, 9, 9, 100, 100);
        add_corner(1, 2, 3, 100, 100);
        add_corner(4, 4, 4, 0, 0);
        add_corner(4, 4, 4, 32'h0002_0000, 0);
        add_corner(4, 4, 4, 0, 32'h0002_0000);
        add_corner(0, 0, 0, 0, 0);
        add_corner(1, 1, 1, 1, 1);
        add_corner(2, 2, 2, 2, 2);
        add_corner(32'hFFFF_FFFF, 32'h7FFF_FFFF, 0, 32'h7FFF_FFFF, 32'h8000_0000);
        add_corner(0, 32'h8000_0000, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
        add_corner(32'h7FFF_FFFF, 0, 32'h8000_0000, 1, 32'hFFFF_FFFF);
        drain_all();

        // Free running.
        add_triangles(80);
        drain_all();

        // Sender idling.
        tx_idle_pct = 60;
        add_triangles(75);
        drain_all();

        // Receiver stalling, with one long hold while corners keep coming.
        tx_idle_pct = 0;
        rx_stall_pct = 60;
        rx_hold_go = 1'b1;
        add_triangles(75);
        while (corner_queue.size() >= 200) @(posedge i_clk);
        tx_pause = 1'b1;
        while (frame_queue.size() != 0) @(posedge i_clk);
        tx_pause = 1'b0;
        drain_all();

        // Both sides idling.
        tx_idle_pct = 14;
        rx_stall_pct = 14;
        add_triangles(85);
        drain_all();

        repeat (250) @(posedge i_clk);
        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end
endmodule
